/* hw/rtl/bankers_resource_allocator_core_defines.svh */
// ----------------------------------------------------------------------------
// Banker's allocator assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BANKERS_RESOURCE_ALLOCATOR_CORE_DEFINES_SVH
`define BANKERS_RESOURCE_ALLOCATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BRA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BRA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define BRA_ASSERT(lbl, clk, rst_n, prop)
`define BRA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* hw/rtl/bra_pkg.sv */
// ----------------------------------------------------------------------------
// Banker's allocator package
// Sizes, codes, payload structs and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int MAX_PROCESSES = 8;
  localparam int MAX_RESOURCES = 4;
  localparam int NUM_AMOUNTS   = 4;
  localparam int UNIT_W        = 8;
  localparam int ROW_W         = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int RES_CNT_W     = $clog2(MAX_RESOURCES + 1);
  localparam int WORK_W        = UNIT_W + CNT_W;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int PROC_CFG_W  = 4;
  localparam int RES_CFG_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PROCESSES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RESOURCES = 1'd1;

  localparam logic [PROC_CFG_W-1:0] RST_ACTIVE_PROCESSES = 4'd8;
  localparam logic [RES_CFG_W-1:0]  RST_ACTIVE_RESOURCES = 3'd4;

  localparam logic [2:0] KIND_REQUEST    = 3'd0;
  localparam logic [2:0] KIND_RELEASE    = 3'd1;
  localparam logic [2:0] KIND_LOAD_NEED  = 3'd2;
  localparam logic [2:0] KIND_LOAD_HELD  = 3'd3;
  localparam logic [2:0] KIND_LOAD_AVAIL = 3'd4;

  localparam logic [2:0] STATUS_DONE         = 3'd0;
  localparam logic [2:0] STATUS_EXCEEDS_NEED = 3'd1;
  localparam logic [2:0] STATUS_NOT_AVAIL    = 3'd2;
  localparam logic [2:0] STATUS_UNSAFE       = 3'd3;
  localparam logic [2:0] STATUS_OVER_HELD    = 3'd4;

  typedef logic [UNIT_W-1:0] unit_t;
  typedef unit_t [MAX_RESOURCES-1:0] row_t;
  typedef logic [WORK_W-1:0] work_t;
  typedef work_t [MAX_RESOURCES-1:0] work_row_t;
  typedef logic [ROW_W-1:0] row_idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] process;
    logic [7:0] amount_0;
    logic [7:0] amount_1;
    logic [7:0] amount_2;
    logic [7:0] amount_3;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       safe;
    logic       process_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SINIT,
    ST_SCAN,
    ST_CHECK,
    ST_ROLLBACK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic latch_item;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic rollback;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic need_rollback;
    logic out_free;
  } dp_sts_t;

endpackage

/* hw/rtl/bra_ctrl.sv */
// ----------------------------------------------------------------------------
// Banker's allocator controller
// Sequences one item: execute, safety scan, optional rollback and rescan, result.
// ----------------------------------------------------------------------------
module bra_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bra_pkg::dp_sts_t sts,
  output bra_pkg::dp_cmd_t cmd
);

  bra_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bra_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bra_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = bra_pkg::ST_EXEC;
      end
      bra_pkg::ST_EXEC:     state_nxt = bra_pkg::ST_SINIT;
      bra_pkg::ST_SINIT:    state_nxt = bra_pkg::ST_SCAN;
      bra_pkg::ST_SCAN: begin
        if (sts.scan_end) state_nxt = bra_pkg::ST_CHECK;
      end
      bra_pkg::ST_CHECK: begin
        if (sts.need_rollback) state_nxt = bra_pkg::ST_ROLLBACK;
        else state_nxt = bra_pkg::ST_OUT;
      end
      bra_pkg::ST_ROLLBACK: state_nxt = bra_pkg::ST_SINIT;
      bra_pkg::ST_OUT: begin
        if (sts.out_free) state_nxt = bra_pkg::ST_IDLE;
      end
      default:              state_nxt = bra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != bra_pkg::ST_IDLE);
    cmd.latch_item = (state_r == bra_pkg::ST_IDLE) && in_valid;
    cmd.exec       = (state_r == bra_pkg::ST_EXEC);
    cmd.scan_init  = (state_r == bra_pkg::ST_SINIT);
    cmd.scan_step  = (state_r == bra_pkg::ST_SCAN);
    cmd.rollback   = (state_r == bra_pkg::ST_ROLLBACK);
    cmd.load_out   = (state_r == bra_pkg::ST_OUT) && sts.out_free;
  end

endmodule

/* hw/rtl/bra_dpath.sv */
// ----------------------------------------------------------------------------
// Banker's allocator datapath
// Allocation tables, request checks, rollback copy, safety scan and result.
// ----------------------------------------------------------------------------
module bra_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bra_pkg::dp_cmd_t                   cmd,
  output bra_pkg::dp_sts_t                   sts,
  input  bra_pkg::in_item_t                  in_data,
  input  logic                               out_stall,
  output logic                               out_valid,
  output bra_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [bra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bra_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [bra_pkg::PROC_CFG_W-1:0] act_proc_r;
  logic [bra_pkg::RES_CFG_W-1:0]  act_res_r;
  bra_pkg::cnt_t                  m;
  logic [bra_pkg::RES_CNT_W-1:0]  n;
  logic [bra_pkg::MAX_RESOURCES-1:0] res_act;

  bra_pkg::row_t     avail_r, avail_nxt;
  bra_pkg::row_t     held_r [bra_pkg::MAX_PROCESSES];
  bra_pkg::row_t     held_nxt [bra_pkg::MAX_PROCESSES];
  bra_pkg::row_t     need_r [bra_pkg::MAX_PROCESSES];
  bra_pkg::row_t     need_nxt [bra_pkg::MAX_PROCESSES];

  bra_pkg::in_item_t item_r;
  bra_pkg::row_t     amt;
  logic              pvalid;
  bra_pkg::row_idx_t row_p, row_sel;
  bra_pkg::row_t     held_row, need_row;

  bra_pkg::row_t     sav_avail_r, sav_avail_nxt;
  bra_pkg::row_t     sav_held_r, sav_held_nxt;
  bra_pkg::row_t     sav_need_r, sav_need_nxt;
  logic [2:0]        status_r, status_nxt;
  logic              req_applied_r, req_applied_nxt;
  logic              exceed_need, no_avail, over_held, row_empty;

  bra_pkg::work_row_t                 work_r, work_nxt;
  logic [bra_pkg::MAX_PROCESSES-1:0]  fin_r, fin_nxt;
  bra_pkg::cnt_t                      done_cnt_r, done_cnt_nxt, done_after;
  bra_pkg::row_idx_t                  idx_r, idx_nxt;
  logic                               pass_prog_r, pass_prog_nxt;
  logic                               safe_r, safe_nxt;
  logic                               fits, take, last, all_done, prog, scan_end;

  logic               out_valid_r, out_valid_nxt;
  bra_pkg::out_item_t out_data_r, out_data_nxt;

  function automatic bra_pkg::unit_t sat_add(bra_pkg::unit_t a, bra_pkg::unit_t b);
    logic [bra_pkg::UNIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[bra_pkg::UNIT_W] ? '1 : s[bra_pkg::UNIT_W-1:0];
  endfunction

  // clamp configured counts
  always_comb begin
    if (act_proc_r == '0) m = bra_pkg::CNT_W'(1);
    else if (int'(act_proc_r) > bra_pkg::MAX_PROCESSES) m = bra_pkg::CNT_W'(bra_pkg::MAX_PROCESSES);
    else m = bra_pkg::CNT_W'(act_proc_r);
    if (act_res_r == '0) n = bra_pkg::RES_CNT_W'(1);
    else if (int'(act_res_r) > bra_pkg::MAX_RESOURCES) n = bra_pkg::RES_CNT_W'(bra_pkg::MAX_RESOURCES);
    else n = bra_pkg::RES_CNT_W'(act_res_r);
    for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
      res_act[j] = (j < int'(n));
    end
  end

  always_comb begin
    for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
      amt[j] = '0;
      if (j == 0) amt[j] = item_r.amount_0;
      else if (j == 1) amt[j] = item_r.amount_1;
      else if (j == 2) amt[j] = item_r.amount_2;
      else if (j == 3) amt[j] = item_r.amount_3;
    end
  end

  assign pvalid   = int'(item_r.process) < int'(m);
  assign row_p    = bra_pkg::ROW_W'(item_r.process);
  assign row_sel  = cmd.scan_step ? idx_r : row_p;
  assign held_row = held_r[row_sel];
  assign need_row = need_r[row_sel];

  always_comb begin
    exceed_need = 1'b0;
    no_avail    = 1'b0;
    over_held   = 1'b0;
    row_empty   = 1'b1;
    fits        = 1'b1;
    for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
      if (res_act[j]) begin
        if (amt[j] > need_row[j]) exceed_need = 1'b1;
        if (amt[j] > avail_r[j]) no_avail = 1'b1;
        if (amt[j] > held_row[j]) over_held = 1'b1;
        if (need_row[j] != '0) row_empty = 1'b0;
        if (bra_pkg::WORK_W'(need_row[j]) > work_r[j]) fits = 1'b0;
      end
    end
  end

  // table update, rollback copy and status
  always_comb begin
    avail_nxt       = avail_r;
    held_nxt        = held_r;
    need_nxt        = need_r;
    sav_avail_nxt   = sav_avail_r;
    sav_held_nxt    = sav_held_r;
    sav_need_nxt    = sav_need_r;
    status_nxt      = status_r;
    req_applied_nxt = req_applied_r;
    if (cmd.exec) begin
      status_nxt      = bra_pkg::STATUS_DONE;
      req_applied_nxt = 1'b0;
      unique case (item_r.kind)
        bra_pkg::KIND_REQUEST: begin
          if (pvalid) begin
            if (exceed_need) begin
              status_nxt = bra_pkg::STATUS_EXCEEDS_NEED;
            end else if (no_avail) begin
              status_nxt = bra_pkg::STATUS_NOT_AVAIL;
            end else begin
              req_applied_nxt = 1'b1;
              sav_avail_nxt   = avail_r;
              sav_held_nxt    = held_row;
              sav_need_nxt    = need_row;
              for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
                if (res_act[j]) begin
                  avail_nxt[j]        = avail_r[j] - amt[j];
                  held_nxt[row_p][j]  = sat_add(held_row[j], amt[j]);
                  need_nxt[row_p][j]  = need_row[j] - amt[j];
                end
              end
            end
          end
        end
        bra_pkg::KIND_RELEASE: begin
          if (pvalid) begin
            if (over_held) begin
              status_nxt = bra_pkg::STATUS_OVER_HELD;
            end else begin
              for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
                if (res_act[j]) begin
                  held_nxt[row_p][j] = held_row[j] - amt[j];
                  avail_nxt[j]       = sat_add(avail_r[j], amt[j]);
                end
              end
            end
          end
        end
        bra_pkg::KIND_LOAD_NEED: begin
          if (pvalid) begin
            for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
              if (res_act[j]) need_nxt[row_p][j] = amt[j];
            end
          end
        end
        bra_pkg::KIND_LOAD_HELD: begin
          if (pvalid) begin
            for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
              if (res_act[j]) held_nxt[row_p][j] = amt[j];
            end
          end
        end
        bra_pkg::KIND_LOAD_AVAIL: begin
          for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
            if (res_act[j]) avail_nxt[j] = amt[j];
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.rollback) begin
      avail_nxt        = sav_avail_r;
      held_nxt[row_p]  = sav_held_r;
      need_nxt[row_p]  = sav_need_r;
      status_nxt       = bra_pkg::STATUS_UNSAFE;
      req_applied_nxt  = 1'b0;
    end
  end

  // safety scan: one process row per cycle, passes repeat until all rows finish or a pass finishes none
  assign take       = !fin_r[idx_r] && fits;
  assign last       = int'(idx_r) == int'(m) - 1;
  assign done_after = done_cnt_r + bra_pkg::CNT_W'(take);
  assign all_done   = (done_after == m);
  assign prog       = pass_prog_r || take;
  assign scan_end   = all_done || (last && !prog);

  always_comb begin
    work_nxt      = work_r;
    fin_nxt       = fin_r;
    done_cnt_nxt  = done_cnt_r;
    idx_nxt       = idx_r;
    pass_prog_nxt = pass_prog_r;
    safe_nxt      = safe_r;
    if (cmd.scan_init) begin
      for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
        work_nxt[j] = bra_pkg::WORK_W'(avail_r[j]);
      end
      fin_nxt       = '0;
      done_cnt_nxt  = '0;
      idx_nxt       = '0;
      pass_prog_nxt = 1'b0;
    end else if (cmd.scan_step) begin
      if (take) begin
        for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
          if (res_act[j]) work_nxt[j] = work_r[j] + bra_pkg::WORK_W'(held_row[j]);
        end
        fin_nxt[idx_r] = 1'b1;
      end
      done_cnt_nxt = done_after;
      if (scan_end) begin
        safe_nxt = all_done;
      end else if (last) begin
        idx_nxt       = '0;
        pass_prog_nxt = 1'b0;
      end else begin
        idx_nxt       = idx_r + 1'b1;
        pass_prog_nxt = prog;
      end
    end
  end

  always_comb begin
    out_data_nxt.status       = status_r;
    out_data_nxt.safe         = safe_r;
    out_data_nxt.process_done = pvalid && row_empty;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_proc_r    <= bra_pkg::RST_ACTIVE_PROCESSES;
      act_res_r     <= bra_pkg::RST_ACTIVE_RESOURCES;
      avail_r       <= '0;
      for (int i = 0; i < bra_pkg::MAX_PROCESSES; i++) begin
        held_r[i] <= '0;
        need_r[i] <= '0;
      end
      status_r      <= bra_pkg::STATUS_DONE;
      req_applied_r <= 1'b0;
      fin_r         <= '0;
      done_cnt_r    <= '0;
      idx_r         <= '0;
      pass_prog_r   <= 1'b0;
      safe_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == bra_pkg::CFG_ACTIVE_PROCESSES)) begin
        act_proc_r <= cfg_wdata[bra_pkg::PROC_CFG_W-1:0];
      end
      if (cfg_we && (cfg_index == bra_pkg::CFG_ACTIVE_RESOURCES)) begin
        act_res_r <= cfg_wdata[bra_pkg::RES_CFG_W-1:0];
      end
      avail_r       <= avail_nxt;
      held_r        <= held_nxt;
      need_r        <= need_nxt;
      status_r      <= status_nxt;
      req_applied_r <= req_applied_nxt;
      fin_r         <= fin_nxt;
      done_cnt_r    <= done_cnt_nxt;
      idx_r         <= idx_nxt;
      pass_prog_r   <= pass_prog_nxt;
      safe_r        <= safe_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) item_r <= in_data;
    sav_avail_r <= sav_avail_nxt;
    sav_held_r  <= sav_held_nxt;
    sav_need_r  <= sav_need_nxt;
    work_r      <= work_nxt;
    if (cmd.load_out) out_data_r <= out_data_nxt;
  end

  assign sts.scan_end      = scan_end;
  assign sts.need_rollback = req_applied_r && !safe_r;
  assign sts.out_free      = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;

endmodule

/* hw/rtl/bankers_resource_allocator_core.sv */
// ----------------------------------------------------------------------------
// Banker's algorithm resource allocator core
// Usage:
//   Input channel in_valid/in_stall/in_data carries one item: kind, process
//   and four amounts. in_stall is low only while the core is idle; a transfer
//   happens when in_valid is high and in_stall is low.
//   Output channel out_valid/out_stall/out_data returns exactly one result
//   (status, safe, process_done) per item from an output register, so a new
//   item may be taken while the previous result still waits.
//   Steps: after the input transfer the item passes through the execute,
//   scan init, safety scan and check states, then its result is loaded into
//   the output register. The safety scan covers m active processes, one row
//   per cycle in passes of m rows. An unsafe request is rolled back and
//   scanned again. One item is in flight at a time and the next is taken in
//   the cycle after its result is loaded, so the scan length sets the rate.
//   When out_stall is high the result holds and the core waits in its final
//   state until the output register frees.
//   cfg_we/cfg_index/cfg_wdata write the active process and resource counts;
//   write them only while idle.
//   Reset (rst_n low, synchronous) clears all tables, sets eight processes
//   and four resources and empties the output register.
// ----------------------------------------------------------------------------
`include "bankers_resource_allocator_core_defines.svh"

module bankers_resource_allocator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bra_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bra_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bra_pkg::dp_cmd_t cmd;
  bra_pkg::dp_sts_t sts;

  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bra_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  `BRA_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)
  `BRA_ASSERT(a_result_from_busy, clk, rst_n, $rose(out_valid) |-> $past(in_stall))
  `BRA_ASSERT(a_rescan_after_rollback, clk, rst_n, cmd.rollback |=> cmd.scan_init)
  `BRA_ASSERT_NEVER(a_rollback_cause, clk, rst_n, cmd.rollback && !sts.need_rollback)

endmodule

/* tb/bankers_resource_allocator_core_tb.sv */
// ----------------------------------------------------------------------------
// Banker's allocator core testbench
// Drives request, release, row load, available load and safety check items
// through the valid/stall input channel. An in-bench allocation table model
// predicts status, safe and process_done for every transfer. Each result
// transfer is compared field by field in order. Runs directed corner cases,
// then scenario-based random traffic over several active process/resource
// counts and three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module bankers_resource_allocator_core_tb;

  localparam logic [2:0] KIND_CHECK = 3'd5;
  localparam int CLK_HALF = 4;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bra_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  bra_pkg::out_item_t out_data;
  logic cfg_we;
  logic [bra_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bra_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bra_pkg::unit_t avail_tbl [bra_pkg::MAX_RESOURCES];
  bra_pkg::unit_t held_tbl [bra_pkg::MAX_PROCESSES][bra_pkg::MAX_RESOURCES];
  bra_pkg::unit_t need_tbl [bra_pkg::MAX_PROCESSES][bra_pkg::MAX_RESOURCES];
  logic [bra_pkg::PROC_CFG_W-1:0] procs_reg;
  logic [bra_pkg::RES_CFG_W-1:0] res_reg;

  bra_pkg::out_item_t pending_results [$];
  int err_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  int unsigned proc_settings [7] = '{8, 1, 3, 15, 0, 5, 8};
  int unsigned res_settings [7] = '{4, 1, 2, 7, 0, 3, 2};

  bankers_resource_allocator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic int unsigned proc_limit();
    if (procs_reg < 1) return 1;
    if (procs_reg > bra_pkg::MAX_PROCESSES) return bra_pkg::MAX_PROCESSES;
    return procs_reg;
  endfunction

  function automatic int unsigned res_limit();
    if (res_reg < 1) return 1;
    if (res_reg > bra_pkg::MAX_RESOURCES) return bra_pkg::MAX_RESOURCES;
    return res_reg;
  endfunction

  function automatic bit state_safe();
    int unsigned work [bra_pkg::MAX_RESOURCES];
    bit fin [bra_pkg::MAX_PROCESSES];
    int unsigned m, n, i, j, finished;
    bit progress, fits;
    m = proc_limit();
    n = res_limit();
    finished = 0;
    for (j = 0; j < bra_pkg::MAX_RESOURCES; j++) work[j] = (j < n) ? avail_tbl[j] : 0;
    for (i = 0; i < bra_pkg::MAX_PROCESSES; i++) fin[i] = 1'b0;
    progress = 1'b1;
    while (progress) begin
      progress = 1'b0;
      for (i = 0; i < m; i++) begin
        if (!progress && !fin[i]) begin
          fits = 1'b1;
          for (j = 0; j < n; j++) begin
            if (need_tbl[i][j] > work[j]) fits = 1'b0;
          end
          if (fits) begin
            for (j = 0; j < n; j++) work[j] += held_tbl[i][j];
            fin[i] = 1'b1;
            finished++;
            progress = 1'b1;
          end
        end
      end
    end
    return finished == m;
  endfunction

  function automatic bra_pkg::out_item_t bankers_update(input bra_pkg::in_item_t it);
    bra_pkg::unit_t amt [bra_pkg::MAX_RESOURCES];
    bra_pkg::unit_t save_avail [bra_pkg::MAX_RESOURCES];
    bra_pkg::unit_t save_held [bra_pkg::MAX_RESOURCES];
    bra_pkg::unit_t save_need [bra_pkg::MAX_RESOURCES];
    int unsigned m, n, p, j, sum;
    bit row_ok, empty;
    bra_pkg::out_item_t res;
    m = proc_limit();
    n = res_limit();
    p = it.process;
    row_ok = (p < m);
    amt[0] = it.amount_0;
    amt[1] = it.amount_1;
    amt[2] = it.amount_2;
    amt[3] = it.amount_3;
    res.status = bra_pkg::STATUS_DONE;
    case (it.kind)
      bra_pkg::KIND_REQUEST: begin
        if (row_ok) begin
          for (j = 0; j < n; j++) begin
            if (res.status == bra_pkg::STATUS_DONE && amt[j] > need_tbl[p][j])
              res.status = bra_pkg::STATUS_EXCEEDS_NEED;
          end
          for (j = 0; j < n; j++) begin
            if (res.status == bra_pkg::STATUS_DONE && amt[j] > avail_tbl[j])
              res.status = bra_pkg::STATUS_NOT_AVAIL;
          end
          if (res.status == bra_pkg::STATUS_DONE) begin
            for (j = 0; j < n; j++) begin
              save_avail[j] = avail_tbl[j];
              save_held[j] = held_tbl[p][j];
              save_need[j] = need_tbl[p][j];
              sum = held_tbl[p][j] + amt[j];
              avail_tbl[j] = avail_tbl[j] - amt[j];
              held_tbl[p][j] = (sum > 255) ? 8'hFF : bra_pkg::unit_t'(sum);
              need_tbl[p][j] = need_tbl[p][j] - amt[j];
            end
            if (!state_safe()) begin
              for (j = 0; j < n; j++) begin
                avail_tbl[j] = save_avail[j];
                held_tbl[p][j] = save_held[j];
                need_tbl[p][j] = save_need[j];
              end
              res.status = bra_pkg::STATUS_UNSAFE;
            end
          end
        end
      end
      bra_pkg::KIND_RELEASE: begin
        if (row_ok) begin
          for (j = 0; j < n; j++) begin
            if (amt[j] > held_tbl[p][j]) res.status = bra_pkg::STATUS_OVER_HELD;
          end
          if (res.status == bra_pkg::STATUS_DONE) begin
            for (j = 0; j < n; j++) begin
              sum = avail_tbl[j] + amt[j];
              held_tbl[p][j] = held_tbl[p][j] - amt[j];
              avail_tbl[j] = (sum > 255) ? 8'hFF : bra_pkg::unit_t'(sum);
            end
          end
        end
      end
      bra_pkg::KIND_LOAD_NEED: begin
        if (row_ok) for (j = 0; j < n; j++) need_tbl[p][j] = amt[j];
      end
      bra_pkg::KIND_LOAD_HELD: begin
        if (row_ok) for (j = 0; j < n; j++) held_tbl[p][j] = amt[j];
      end
      bra_pkg::KIND_LOAD_AVAIL: begin
        for (j = 0; j < n; j++) avail_tbl[j] = amt[j];
      end
      default: ;
    endcase
    res.safe = state_safe();
    empty = row_ok;
    for (j = 0; j < n; j++) begin
      if (row_ok && need_tbl[p][j] != 0) empty = 1'b0;
    end
    res.process_done = empty;
    return res;
  endfunction

  function automatic bra_pkg::in_item_t mk_item(input logic [2:0] kind, input int unsigned p,
                                                input int unsigned a0, input int unsigned a1,
                                                input int unsigned a2, input int unsigned a3);
    bra_pkg::in_item_t it;
    it.kind = kind;
    it.process = p[2:0];
    it.amount_0 = a0[7:0];
    it.amount_1 = a1[7:0];
    it.amount_2 = a2[7:0];
    it.amount_3 = a3[7:0];
    return it;
  endfunction

  function automatic bra_pkg::in_item_t random_item();
    int unsigned m, n, p, j, sel, lim;
    logic [2:0] kind;
    bra_pkg::unit_t amt [bra_pkg::MAX_RESOURCES];
    m = proc_limit();
    n = res_limit();
    sel = $urandom_range(0, 99);
    p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, m - 1);
    for (j = 0; j < bra_pkg::MAX_RESOURCES; j++) amt[j] = bra_pkg::unit_t'($urandom);
    if (sel < 45) begin
      kind = bra_pkg::KIND_REQUEST;
      if (sel < 33) begin
        for (j = 0; j < n; j++) begin
          lim = (need_tbl[p][j] < avail_tbl[j]) ? need_tbl[p][j] : avail_tbl[j];
          amt[j] = bra_pkg::unit_t'($urandom_range(0, lim));
        end
      end else if (sel < 39) begin
        for (j = 0; j < n; j++) amt[j] = bra_pkg::unit_t'($urandom_range(0, need_tbl[p][j]));
        j = $urandom_range(0, n - 1);
        if (need_tbl[p][j] != 8'hFF) amt[j] = need_tbl[p][j] + 8'd1;
      end
    end else if (sel < 65) begin
      kind = bra_pkg::KIND_RELEASE;
      if (sel < 60) begin
        for (j = 0; j < n; j++) amt[j] = bra_pkg::unit_t'($urandom_range(0, held_tbl[p][j]));
      end
    end else if (sel < 73) begin
      kind = bra_pkg::KIND_LOAD_NEED;
      if (sel < 71) for (j = 0; j < n; j++) amt[j] = bra_pkg::unit_t'($urandom_range(0, 20));
    end else if (sel < 80) begin
      kind = bra_pkg::KIND_LOAD_HELD;
      if (sel < 78) for (j = 0; j < n; j++) amt[j] = bra_pkg::unit_t'($urandom_range(0, 8));
    end else if (sel < 88) begin
      kind = bra_pkg::KIND_LOAD_AVAIL;
      if (sel < 86) for (j = 0; j < n; j++) amt[j] = bra_pkg::unit_t'($urandom_range(0, 15));
    end else begin
      kind = 3'($urandom_range(KIND_CHECK, 7));
    end
    return mk_item(kind, p, amt[0], amt[1], amt[2], amt[3]);
  endfunction

  task automatic send_item(input bra_pkg::in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(bankers_update(it));
  endtask

  // hold off until every result is back, then write while the core is idle
  task automatic write_reg(input logic [bra_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[bra_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bra_pkg::CFG_ACTIVE_PROCESSES) procs_reg = val[bra_pkg::PROC_CFG_W-1:0];
    else res_reg = val[bra_pkg::RES_CFG_W-1:0];
  endtask

  task automatic load_scenario();
    int unsigned p;
    send_item(mk_item(bra_pkg::KIND_LOAD_AVAIL, 0, $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15)));
    for (p = 0; p < proc_limit(); p++) begin
      send_item(mk_item(bra_pkg::KIND_LOAD_NEED, p, $urandom_range(0, 20),
                        $urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20)));
      send_item(mk_item(bra_pkg::KIND_LOAD_HELD, p, $urandom_range(0, 8),
                        $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 8)));
    end
  endtask

  task automatic test_reset_state();
    send_item(mk_item(KIND_CHECK, 0, 0, 0, 0, 0));
  endtask

  task automatic test_loads_and_checks();
    send_item(mk_item(bra_pkg::KIND_LOAD_AVAIL, 0, 255, 255, 255, 255));
    send_item(mk_item(bra_pkg::KIND_LOAD_NEED, 7, 255, 255, 255, 255));
    send_item(mk_item(bra_pkg::KIND_LOAD_HELD, 7, 0, 0, 0, 0));
    send_item(mk_item(3'd6, 7, 255, 0, 255, 0));
    send_item(mk_item(3'd7, 3, 0, 255, 0, 255));
  endtask

  task automatic test_requests();
    send_item(mk_item(bra_pkg::KIND_REQUEST, 0, 1, 0, 0, 0));
    send_item(mk_item(bra_pkg::KIND_LOAD_NEED, 0, 10, 10, 10, 10));
    send_item(mk_item(bra_pkg::KIND_LOAD_AVAIL, 0, 4, 4, 4, 4));
    send_item(mk_item(bra_pkg::KIND_REQUEST, 0, 5, 0, 0, 0));
    send_item(mk_item(bra_pkg::KIND_REQUEST, 0, 4, 4, 4, 4));
    send_item(mk_item(bra_pkg::KIND_LOAD_AVAIL, 0, 255, 255, 255, 255));
    send_item(mk_item(bra_pkg::KIND_LOAD_HELD, 0, 250, 250, 250, 250));
    send_item(mk_item(bra_pkg::KIND_REQUEST, 0, 10, 10, 10, 10));
  endtask

  task automatic test_releases();
    send_item(mk_item(bra_pkg::KIND_RELEASE, 1, 1, 0, 0, 0));
    send_item(mk_item(bra_pkg::KIND_RELEASE, 0, 255, 255, 255, 255));
    send_item(mk_item(bra_pkg::KIND_RELEASE, 7, 0, 0, 0, 0));
  endtask

  task automatic test_inactive_rows();
    write_reg(bra_pkg::CFG_ACTIVE_PROCESSES, 2);
    send_item(mk_item(bra_pkg::KIND_REQUEST, 5, 0, 0, 0, 0));
    send_item(mk_item(bra_pkg::KIND_RELEASE, 5, 1, 1, 1, 1));
    send_item(mk_item(bra_pkg::KIND_LOAD_NEED, 5, 9, 9, 9, 9));
    send_item(mk_item(bra_pkg::KIND_LOAD_HELD, 5, 9, 9, 9, 9));
    send_item(mk_item(KIND_CHECK, 5, 0, 0, 0, 0));
  endtask

  task automatic test_register_limits();
    write_reg(bra_pkg::CFG_ACTIVE_PROCESSES, 0);
    write_reg(bra_pkg::CFG_ACTIVE_RESOURCES, 0);
    send_item(mk_item(KIND_CHECK, 0, 0, 0, 0, 0));
    send_item(mk_item(bra_pkg::KIND_LOAD_NEED, 0, 3, 7, 7, 7));
    write_reg(bra_pkg::CFG_ACTIVE_PROCESSES, 15);
    write_reg(bra_pkg::CFG_ACTIVE_RESOURCES, 7);
    send_item(mk_item(KIND_CHECK, 6, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic();
    int unsigned regime, slot, k, setting;
    for (regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin idle_pct = 11; stall_pct = 85; end
        1: begin idle_pct = 85; stall_pct = 11; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (slot = 0; slot < 3; slot++) begin
        setting = (regime * 3 + slot) % 7;
        write_reg(bra_pkg::CFG_ACTIVE_PROCESSES, proc_settings[setting]);
        write_reg(bra_pkg::CFG_ACTIVE_RESOURCES, res_settings[setting]);
        for (k = 0; k < 72; k++) begin
          if (k % 36 == 0) load_scenario();
          send_item(random_item());
        end
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    bra_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: expected none, actual %0h", $time, out_data);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          err_count++;
        end
        if (out_data.safe !== want.safe) begin
          $display("%0t: safe expected %0d actual %0d", $time, want.safe, out_data.safe);
          err_count++;
        end
        if (out_data.process_done !== want.process_done) begin
          $display("%0t: process_done expected %0d actual %0d", $time,
                   want.process_done, out_data.process_done);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    procs_reg = bra_pkg::RST_ACTIVE_PROCESSES;
    res_reg = bra_pkg::RST_ACTIVE_RESOURCES;
    for (int j = 0; j < bra_pkg::MAX_RESOURCES; j++) begin
      avail_tbl[j] = '0;
      for (int i = 0; i < bra_pkg::MAX_PROCESSES; i++) begin
        held_tbl[i][j] = '0;
        need_tbl[i][j] = '0;
      end
    end
    idle_pct = 11;
    stall_pct = 85;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_loads_and_checks();
    test_requests();
    test_releases();
    test_inactive_rows();
    test_register_limits();
    test_random_traffic();

    // drain outstanding results
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("bankers_resource_allocator_core regression: pass");
    end else begin
      $display("bankers_resource_allocator_core regression: fail");
    end
    $finish;
  end

  initial begin
    #6_400_000;
    $display("bankers_resource_allocator_core regression: fail");
    $finish;
  end

endmodule
